// ===== rtl/quad_scanline_span_fill_top_macros.svh =====
// assertion macros shared by the checker
`ifndef QUAD_SCANLINE_SPAN_FILL_TOP_MACROS_SVH
`define QUAD_SCANLINE_SPAN_FILL_TOP_MACROS_SVH
// a condition implies a consequence in the next cycle
`define QSF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
	else $error("qsf check failed");
// a condition implies a consequence in the same cycle
`define QSF_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
	else $error("qsf check failed");
`endif

// ===== rtl/qsf_pkg.sv =====
// ----------------------------------------------------------------------------
// qsf_pkg
// types and constants for the quad span filler
// ----------------------------------------------------------------------------
package qsf_pkg;
	localparam int MAX_SPAN = 20;
	localparam int CW = 12;
	localparam int OW = 11;
	localparam int RW = 12;
	localparam int RI_LENS_W = 0;
	localparam int RI_LENS_H = 1;
	localparam int RI_PLATE  = 2;
	localparam logic [RW-1:0] LENS_W_RST = 12'd640;
	localparam logic [RW-1:0] LENS_H_RST = 12'd480;
	localparam logic [RW-1:0] PLATE_RST  = 12'd480;

	localparam logic [1:0] KIND_REJECT = 2'd0;
	localparam logic [1:0] KIND_HLINE  = 2'd1;
	localparam logic [1:0] KIND_VLINE  = 2'd2;
	localparam logic [1:0] KIND_GEN    = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] top_left_x;
		logic signed [CW-1:0] top_left_y;
		logic signed [CW-1:0] top_right_x;
		logic signed [CW-1:0] top_right_y;
		logic signed [CW-1:0] bottom_left_x;
		logic signed [CW-1:0] bottom_left_y;
		logic signed [CW-1:0] bottom_right_x;
		logic signed [CW-1:0] bottom_right_y;
		logic [3:0] source_plate;
		logic [OW-1:0] source_x;
		logic [OW-1:0] source_y;
	} quad_in_t;

	typedef struct packed {
		logic [OW-1:0] row_y;
		logic [OW-1:0] span_start;
		logic [OW-1:0] span_end;
		logic span_valid;
		logic [3:0] out_plate;
		logic [OW-1:0] out_source_x;
		logic [OW-1:0] out_source_y;
		logic last;
	} span_out_t;

	// classified quad as queued between front and back
	typedef struct packed {
		logic [1:0] kind;
		logic signed [CW-1:0] cx0, cy0, cx1, cy1, cx2, cy2, cx3, cy3;
		logic signed [CW-1:0] minx, maxx, miny, maxy;
		logic [3:0] plate;
		logic [OW-1:0] sx, sy;
	} job_t;
endpackage

// ===== rtl/qsf_front.sv =====
// ----------------------------------------------------------------------------
// qsf_front
// bounding box and classification of one quad
// ----------------------------------------------------------------------------
module qsf_front import qsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  quad_in_t in_data,
	output logic in_stall,
	input  logic [RW-1:0] plate_size,
	output logic job_valid,
	output job_t job,
	input  logic job_stall
);
	logic signed [CW-1:0] cx [4];
	logic signed [CW-1:0] cy [4];
	logic signed [CW-1:0] mnx, mxx, mny, mxy;
	logic [CW:0] wx, wy;
	job_t job_s1;
	logic vld_s1;

	assign cx[0] = in_data.top_left_x;     assign cy[0] = in_data.top_left_y;
	assign cx[1] = in_data.top_right_x;    assign cy[1] = in_data.top_right_y;
	assign cx[2] = in_data.bottom_right_x; assign cy[2] = in_data.bottom_right_y;
	assign cx[3] = in_data.bottom_left_x;  assign cy[3] = in_data.bottom_left_y;

	always_comb begin
		mnx = cx[0]; mxx = cx[0]; mny = cy[0]; mxy = cy[0];
		for (int i = 1; i < 4; i++) begin
			if (cx[i] < mnx) mnx = cx[i];
			if (cx[i] > mxx) mxx = cx[i];
			if (cy[i] < mny) mny = cy[i];
			if (cy[i] > mxy) mxy = cy[i];
		end
		wx = (CW+1)'($signed({mxx[CW-1], mxx}) - $signed({mnx[CW-1], mnx}));
		wy = (CW+1)'($signed({mxy[CW-1], mxy}) - $signed({mny[CW-1], mny}));
	end

	assign in_stall = vld_s1 && job_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			job_s1.cx0 <= cx[0]; job_s1.cy0 <= cy[0];
			job_s1.cx1 <= cx[1]; job_s1.cy1 <= cy[1];
			job_s1.cx2 <= cx[2]; job_s1.cy2 <= cy[2];
			job_s1.cx3 <= cx[3]; job_s1.cy3 <= cy[3];
			job_s1.minx <= mnx; job_s1.maxx <= mxx;
			job_s1.miny <= mny; job_s1.maxy <= mxy;
			job_s1.plate <= in_data.source_plate;
			job_s1.sx <= in_data.source_x;
			job_s1.sy <= in_data.source_y;
			if (wx > (CW+1)'(MAX_SPAN) || wy > (CW+1)'(MAX_SPAN) ||
			    {1'b0, in_data.source_x} >= plate_size ||
			    {1'b0, in_data.source_y} >= plate_size) begin
				job_s1.kind <= KIND_REJECT;
			end else if (mny == mxy) begin
				job_s1.kind <= KIND_HLINE;
			end else if (mnx == mxx) begin
				job_s1.kind <= KIND_VLINE;
			end else begin
				job_s1.kind <= KIND_GEN;
			end
		end
	end

	assign job_valid = vld_s1;
	assign job = job_s1;
endmodule

// ===== rtl/qsf_queue.sv =====
// ----------------------------------------------------------------------------
// qsf_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module qsf_queue import qsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	input  job_t wr_data,
	output logic wr_stall,
	output logic rd_valid,
	output job_t rd_data,
	input  logic rd_take
);
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_take && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

// ===== rtl/qsf_div.sv =====
// ----------------------------------------------------------------------------
// qsf_div
// restoring divider, one quotient bit a cycle, truncating toward zero
// ----------------------------------------------------------------------------
module qsf_div import qsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [2*CW+2:0] num,
	input  logic [CW:0] den,
	output logic busy,
	output logic signed [CW+1:0] quo
);
	localparam int NW = 2*CW + 2;
	logic [NW-1:0] n_q, q_q;
	logic [NW:0] r_q;
	logic [CW:0] d_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic [NW:0] r_sh;
	logic [NW-1:0] qq;

	assign r_sh = {r_q[NW-1:0], n_q[NW-1]};
	assign busy = (cnt_q != 6'd0);
	assign qq = neg_q ? NW'(-q_q) : q_q;
	assign quo = (CW+2)'(qq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW];
			n_q <= num[NW] ? NW'(-num) : NW'(num);
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
		end else if (busy) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (r_sh >= {{(NW-CW){1'b0}}, d_q}) begin
				r_q <= r_sh - {{(NW-CW){1'b0}}, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/qsf_back.sv =====
// ----------------------------------------------------------------------------
// qsf_back
// row walker: edge crossings, span ordering, clipping, output register
// ----------------------------------------------------------------------------
module qsf_back import qsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_take,
	input  logic [RW-1:0] lens_w,
	input  logic [RW-1:0] lens_height,
	output logic out_valid,
	output span_out_t out_data,
	input  logic out_stall
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROW  = 3'd1;
	localparam logic [2:0] ST_EDGE = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam int VW = CW + 2;

	logic [2:0] st_q;
	job_t j_q;
	logic signed [VW-1:0] y_q, a_q, b_q;
	logic signed [VW-1:0] tx0_q, tx1_q;
	logic [1:0] ei_q;
	logic t_q;
	logic fin_q, bad_q;
	logic dstart;
	logic dbusy, dbusy_q;
	logic signed [VW-1:0] dquo;
	logic signed [2*CW+2:0] dnum;
	logic [CW:0] dden;

	logic signed [CW-1:0] ix, iy, jx, jy;
	logic signed [VW-1:0] ys;
	logic hit;
	logic signed [CW+1:0] dy, dx, ady;
	logic signed [2*CW+2:0] num;

	span_out_t o_q;
	logic ov_q;
	logic room;

	// pick edge: i visits tl,tr,br,bl with j the previous corner
	always_comb begin
		ix = j_q.cx0; iy = j_q.cy0; jx = j_q.cx3; jy = j_q.cy3;
		case (ei_q)
			2'd0: begin ix = j_q.cx0; iy = j_q.cy0; jx = j_q.cx3; jy = j_q.cy3; end
			2'd1: begin ix = j_q.cx1; iy = j_q.cy1; jx = j_q.cx0; jy = j_q.cy0; end
			2'd2: begin ix = j_q.cx2; iy = j_q.cy2; jx = j_q.cx1; jy = j_q.cy1; end
			2'd3: begin ix = j_q.cx3; iy = j_q.cy3; jx = j_q.cx2; jy = j_q.cy2; end
			default: begin ix = j_q.cx0; iy = j_q.cy0; jx = j_q.cx3; jy = j_q.cy3; end
		endcase
		ys = y_q;
		hit = (VW'(iy) < ys && ys <= VW'(jy)) || (VW'(jy) < ys && ys <= VW'(iy));
		dy = (CW+2)'(jy) - (CW+2)'(iy);
		dx = (CW+2)'(jx) - (CW+2)'(ix);
		num = (2*CW+3)'(ix) * (2*CW+3)'(dy) + (2*CW+3)'(ys - VW'(iy)) * (2*CW+3)'(dx);
		ady = dy[CW+1] ? -dy : dy;
	end

	assign dnum = dy[CW+1] ? -num : num;
	assign dden = (CW+1)'(ady);
	assign dstart = (st_q == ST_EDGE) && hit;

	qsf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.busy(dbusy), .quo(dquo)
	);

	// clipping of the pending span
	logic signed [VW-1:0] ca, cb, lw1;
	logic cv;
	always_comb begin
		lw1 = VW'({2'b0, lens_w}) - VW'(1);
		ca = (a_q < 0) ? '0 : a_q;
		cb = (b_q > lw1) ? lw1 : b_q;
		cv = !bad_q && y_q >= 0 && y_q < VW'({2'b0, lens_height}) && ca <= cb;
	end

	assign room = !ov_q || !out_stall;
	assign job_take = (st_q == ST_IDLE) && job_valid;
	assign out_valid = ov_q;
	assign out_data = o_q;

	logic signed [VW-1:0] s0, s1;
	assign s0 = (tx0_q > tx1_q) ? tx1_q : tx0_q;
	assign s1 = (tx0_q > tx1_q) ? tx0_q : tx1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (st_q == ST_EMIT && room) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (job_valid) st_q <= (job.kind == KIND_GEN) ? ST_ROW : ST_EMIT;
				ST_ROW: st_q <= ST_EDGE;
				ST_EDGE: begin
					if (hit) st_q <= ST_DIV;
					else if (ei_q == 2'd3) st_q <= ST_EMIT;
				end
				ST_DIV: if (!dbusy && !dbusy_q) begin
					st_q <= (t_q || ei_q == 2'd3) ? ST_EMIT : ST_EDGE;
				end
				// an overwide row ends the quad
				ST_EMIT: if (room) begin
					st_q <= (fin_q || bad_q) ? ST_IDLE :
					        ((j_q.kind == KIND_GEN) ? ST_ROW : ST_EMIT);
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		dbusy_q <= dstart;
		case (st_q)
			ST_IDLE: if (job_valid) begin
				j_q <= job;
				y_q <= VW'(job.miny);
				a_q <= VW'(job.minx);
				b_q <= (job.kind == KIND_HLINE) ? VW'(job.maxx) : VW'(job.minx);
				bad_q <= (job.kind == KIND_REJECT);
				fin_q <= (job.kind == KIND_REJECT) || (job.kind == KIND_HLINE) ||
				         (job.miny == job.maxy);
			end
			ST_ROW: begin
				tx0_q <= VW'(j_q.minx);
				tx1_q <= VW'(j_q.maxx);
				ei_q <= 2'd0;
				t_q <= 1'b0;
			end
			ST_EDGE: if (!hit && ei_q != 2'd3) ei_q <= ei_q + 2'd1;
			else if (!hit) begin
				a_q <= s0; b_q <= s1;
				bad_q <= (s1 - s0) > VW'(MAX_SPAN);
			end
			ST_DIV: if (!dbusy && !dbusy_q) begin
				if (t_q) tx1_q <= dquo; else tx0_q <= dquo;
				if (t_q || ei_q == 2'd3) begin
					a_q <= t_q ? ((tx0_q > dquo) ? dquo : tx0_q) : ((dquo > tx1_q) ? tx1_q : dquo);
					b_q <= t_q ? ((tx0_q > dquo) ? tx0_q : dquo) : ((dquo > tx1_q) ? dquo : tx1_q);
					bad_q <= t_q ? (((tx0_q > dquo) ? tx0_q - dquo : dquo - tx0_q) > VW'(MAX_SPAN))
					             : (((dquo > tx1_q) ? dquo - tx1_q : tx1_q - dquo) > VW'(MAX_SPAN));
				end else begin
					ei_q <= ei_q + 2'd1;
				end
				t_q <= 1'b1;
			end
			// a rejected or overwide span goes out with zero row and span fields and last set
			ST_EMIT: if (room) begin
				o_q.row_y <= cv ? OW'(y_q) : '0;
				o_q.span_start <= cv ? OW'(ca) : '0;
				o_q.span_end <= cv ? OW'(cb) : '0;
				o_q.span_valid <= cv;
				o_q.out_plate <= j_q.plate;
				o_q.out_source_x <= j_q.sx;
				o_q.out_source_y <= j_q.sy;
				o_q.last <= fin_q || bad_q;
				y_q <= y_q + VW'(1);
				a_q <= VW'(j_q.minx);
				b_q <= VW'(j_q.minx);
				if (bad_q || y_q + VW'(1) == VW'(j_q.maxy)) fin_q <= 1'b1;
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/quad_scanline_span_fill_top.sv =====
// ----------------------------------------------------------------------------
// quad_scanline_span_fill_top
// turns a small quad into clipped horizontal spans, one per screen row
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   quad_in_t (corners, plate pixel)
// out      out  out_valid/out_stall span_out_t (one span, last on final)
// cfg      in   cfg_we              cfg_index, cfg_data
//
// front stage classifies a quad into a register, then queues it (two entries)
// rejected quads and horizontal lines: the walker takes the quad, then emits one span
// vertical lines: a take, then one row per cycle while out_stall is low
// general quads: per row up to two crossings, each an edge test plus a
// serial divide; the divider sets the rate
// reset clears control only; registers take their documented reset values
// out_stall holds the output register; the walker waits, the queue absorbs
module quad_scanline_span_fill_top import qsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  quad_in_t in_data,
	output logic in_stall,
	output logic out_valid,
	output span_out_t out_data,
	input  logic out_stall,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [RW-1:0] cfg_data
);
	logic [RW-1:0] lens_w_q, lens_h_q, plate_q;
	logic fv, qs, qv, take;
	job_t fj, qj;

	// configuration registers; index three falls through unused
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_w_q <= LENS_W_RST;
			lens_h_q <= LENS_H_RST;
			plate_q <= PLATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				2'(RI_LENS_W): lens_w_q <= cfg_data;
				2'(RI_LENS_H): lens_h_q <= cfg_data;
				2'(RI_PLATE):  plate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	qsf_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_data(in_data),
		.in_stall(in_stall), .plate_size(plate_q),
		.job_valid(fv), .job(fj), .job_stall(qs)
	);

	qsf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(fv), .wr_data(fj), .wr_stall(qs),
		.rd_valid(qv), .rd_data(qj), .rd_take(take)
	);

	qsf_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(qv), .job(qj), .job_take(take),
		.lens_w(lens_w_q), .lens_height(lens_h_q),
		.out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
	);
endmodule

// ===== rtl/qsf_checker.sv =====
// ----------------------------------------------------------------------------
// qsf_checker
// port-level checks for the span filler
// ----------------------------------------------------------------------------
`include "quad_scanline_span_fill_top_macros.svh"
module qsf_checker import qsf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input span_out_t out_data
);
	`QSF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`QSF_ASSERT_NOW(a_inv_zero, clk, arst_n, out_valid && !out_data.span_valid, out_data.row_y == '0 && out_data.span_start == '0)
	`QSF_ASSERT_NOW(a_order, clk, arst_n, out_valid && out_data.span_valid, out_data.span_start <= out_data.span_end)
endmodule

bind quad_scanline_span_fill_top qsf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data)
);

// ===== test/quad_scanline_span_fill_top_tb.sv =====
// ----------------------------------------------------------------------------
// quad_scanline_span_fill_top_tb
// self-checking bench for the quad span filler: directed quads, then random
// quads under several lens and plate settings, checked against a predictor
// ----------------------------------------------------------------------------
module quad_scanline_span_fill_top_tb;
	import qsf_pkg::*;

	localparam int WATCHDOG_LIMIT = 30000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_QUADS = 330;
	localparam int QW = $bits(quad_in_t);
	localparam logic [1:0] RI_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	quad_in_t in_data;
	logic in_stall;
	logic out_valid;
	span_out_t out_data;
	logic out_stall;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [RW-1:0] cfg_data;

	// predictor copy of the registers
	int lens_w_q, lens_h_q, plate_q;
	// expected spans, oldest first
	span_out_t span_q[$];
	int err_cnt;
	int idle_cnt;
	bit burst_mode;

	typedef struct {
		quad_in_t q;
		bit typed;
		span_out_t e;
	} quad_case_t;
	quad_case_t cases[$];

	quad_scanline_span_fill_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
		.out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic void push_span(int y, int a, int b, bit ok, quad_in_t q);
		span_out_t s;
		s = '0;
		if (ok && (y < 0 || y >= lens_h_q))
			ok = 0;
		if (ok) begin
			if (a < 0)
				a = 0;
			if (b > lens_w_q - 1)
				b = lens_w_q - 1;
			if (a > b)
				ok = 0;
		end
		if (ok) begin
			s.row_y = y[OW-1:0];
			s.span_start = a[OW-1:0];
			s.span_end = b[OW-1:0];
			s.span_valid = 1'b1;
		end
		s.out_plate = q.source_plate;
		s.out_source_x = q.source_x;
		s.out_source_y = q.source_y;
		span_q.push_back(s);
	endfunction

	function automatic void predict_spans(quad_in_t q);
		int cx[4], cy[4];
		int minx, maxx, miny, maxy, t, j, tx0, tx1, sw;
		longint dy, dx, num, xc;
		// corner order around the quad: tl, tr, br, bl
		cx[0] = q.top_left_x;     cy[0] = q.top_left_y;
		cx[1] = q.top_right_x;    cy[1] = q.top_right_y;
		cx[2] = q.bottom_right_x; cy[2] = q.bottom_right_y;
		cx[3] = q.bottom_left_x;  cy[3] = q.bottom_left_y;
		minx = cx[0]; maxx = cx[0]; miny = cy[0]; maxy = cy[0];
		for (int i = 1; i < 4; i++) begin
			if (cx[i] < minx) minx = cx[i];
			if (cx[i] > maxx) maxx = cx[i];
			if (cy[i] < miny) miny = cy[i];
			if (cy[i] > maxy) maxy = cy[i];
		end
		if (maxx - minx > MAX_SPAN || maxy - miny > MAX_SPAN ||
				int'(q.source_x) >= plate_q || int'(q.source_y) >= plate_q) begin
			push_span(0, 0, 0, 0, q);
		end else if (miny == maxy) begin
			push_span(miny, minx, maxx, 1, q);
		end else if (minx == maxx) begin
			for (int y = miny; y <= maxy; y++)
				push_span(y, minx, minx, 1, q);
		end else begin
			for (int y = miny; y <= maxy; y++) begin
				tx0 = minx;
				tx1 = maxx;
				t = 0;
				j = 3;
				for (int i = 0; i < 4; i++) begin
					// half-open crossing test on edge j -> i
					if ((cy[i] < y && y <= cy[j]) || (cy[j] < y && y <= cy[i])) begin
						dy = cy[j] - cy[i];
						dx = cx[j] - cx[i];
						num = longint'(cx[i]) * dy + longint'(y - cy[i]) * dx;
						if (dy < 0) begin
							num = -num;
							dy = -dy;
						end
						xc = num / dy;
						if (t == 0)
							tx0 = int'(xc);
						else
							tx1 = int'(xc);
						t++;
						if (t == 2)
							break;
					end
					j = i;
				end
				if (tx0 > tx1) begin
					sw = tx0; tx0 = tx1; tx1 = sw;
				end
				if (tx1 - tx0 > MAX_SPAN) begin
					push_span(0, 0, 0, 0, q);
					break;
				end
				push_span(y, tx0, tx1, 1, q);
			end
		end
		span_q[span_q.size()-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic quad_in_t mk_quad(int tlx, int tly, int trx, int tr_y,
			int brx, int bry, int blx, int bly, int plate, int sx, int sy);
		quad_in_t q;
		q.top_left_x = tlx[CW-1:0];     q.top_left_y = tly[CW-1:0];
		q.top_right_x = trx[CW-1:0];    q.top_right_y = tr_y[CW-1:0];
		q.bottom_right_x = brx[CW-1:0]; q.bottom_right_y = bry[CW-1:0];
		q.bottom_left_x = blx[CW-1:0];  q.bottom_left_y = bly[CW-1:0];
		q.source_plate = plate[3:0];
		q.source_x = sx[OW-1:0];
		q.source_y = sy[OW-1:0];
		return q;
	endfunction

	function automatic span_out_t mk_span(int y, int a, int b, bit ok, quad_in_t q);
		span_out_t s;
		s = '0;
		s.row_y = y[OW-1:0];
		s.span_start = a[OW-1:0];
		s.span_end = b[OW-1:0];
		s.span_valid = ok;
		s.out_plate = q.source_plate;
		s.out_source_x = q.source_x;
		s.out_source_y = q.source_y;
		s.last = 1'b1;
		return s;
	endfunction

	// gap lengths: mostly short, a few long, none during a burst
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one quad transfer on the input side; expected spans queued on accept
	task automatic send_quad(quad_in_t q, bit typed, span_out_t e);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= q;
		// stall is stable from mid-cycle up to the edge
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		if (typed)
			span_q.push_back(e);
		else
			predict_spans(q);
	endtask

	// wait until every expected span has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (span_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one write, then cfg_we is dropped and held low before anything else is driven
	task automatic write_reg(logic [1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[RW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			RI_LENS_W[1:0]: lens_w_q = val[RW-1:0];
			RI_LENS_H[1:0]: lens_h_q = val[RW-1:0];
			RI_PLATE[1:0]: plate_q = val[RW-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_lens(int w, int h, int p);
		write_reg(RI_LENS_W[1:0], w);
		write_reg(RI_LENS_H[1:0], h);
		write_reg(RI_PLATE[1:0], p);
	endtask

	// random quad placed near the lens area, mostly well formed
	function automatic quad_in_t rand_quad();
		quad_in_t q;
		int w, h, ox, oy, r, sx, sy;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// pure noise over every bit
			q = QW'({$urandom, $urandom, $urandom, $urandom});
			return q;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			w = $urandom_range(0, 3); h = $urandom_range(0, 3);
		end else if (r < 94) begin
			w = $urandom_range(4, MAX_SPAN); h = $urandom_range(4, MAX_SPAN);
		end else begin
			w = $urandom_range(MAX_SPAN - 1, MAX_SPAN + 4);
			h = $urandom_range(MAX_SPAN - 1, MAX_SPAN + 4);
		end
		r = $urandom_range(0, 9);
		if (r == 0) w = 0;
		if (r == 1) h = 0;
		if (r == 2) begin w = 0; h = 0; end
		ox = $urandom_range(0, lens_w_q + 40) - 30;
		oy = $urandom_range(0, lens_h_q + 40) - 30;
		if (ox > 2047 - w) ox = 2047 - w;
		if (oy > 2047 - h) oy = 2047 - h;
		if ($urandom_range(0, 99) < 90 && plate_q > 0) begin
			sx = $urandom_range(0, (plate_q > 2048 ? 2048 : plate_q) - 1);
			sy = $urandom_range(0, (plate_q > 2048 ? 2048 : plate_q) - 1);
		end else begin
			sx = $urandom_range(0, 2047);
			sy = $urandom_range(0, 2047);
		end
		q = mk_quad(ox + $urandom_range(0, w), oy + $urandom_range(0, h),
			ox + $urandom_range(0, w), oy + $urandom_range(0, h),
			ox + $urandom_range(0, w), oy + $urandom_range(0, h),
			ox + $urandom_range(0, w), oy + $urandom_range(0, h),
			$urandom_range(0, 15), sx, sy);
		// pin the box extremes now and then so degenerate shapes stay exact
		if (w == 0 || h == 0 || $urandom_range(0, 3) == 0) begin
			q.top_left_x = ox[CW-1:0]; q.top_left_y = oy[CW-1:0];
			q.bottom_right_x = CW'(ox + w); q.bottom_right_y = CW'(oy + h);
		end
		return q;
	endfunction

	// ------------------------------------------------------------------
	// output side: random stall, check at mid-cycle before the accepting edge
	// ------------------------------------------------------------------
	int stall_left;
	bit stall_on;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			stall_on <= 1'b0;
		end else if (stall_left == 0) begin
			// pick the next stretch of stall or flow
			stall_on <= !burst_mode && ($urandom_range(0, 99) < 35);
			stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
				: $urandom_range(10, 40);
			out_stall <= 1'b0;
		end else begin
			stall_left <= stall_left - 1;
			out_stall <= stall_on;
		end
	end

	span_out_t want;
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (out_valid && !out_stall) begin
				if (span_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 20)
						$display("%0t: unexpected span transfer %p", $time, out_data);
				end else begin
					want = span_q.pop_front();
					if (out_data !== want) begin
						err_cnt++;
						if (err_cnt <= 20)
							$display("%0t: span mismatch expected %p actual %p",
								$time, want, out_data);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d spans outstanding", $time, span_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		quad_in_t q;
		span_out_t none;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		err_cnt = 0;
		idle_cnt = 0;
		burst_mode = 0;
		none = '0;
		lens_w_q = LENS_W_RST;
		lens_h_q = LENS_H_RST;
		plate_q = PLATE_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed quads under the reset settings
		q = mk_quad(5, 7, 5, 7, 5, 7, 5, 7, 3, 1, 2);
		cases.push_back('{q, 1, mk_span(7, 5, 5, 1, q)});
		// box one wider than the limit
		q = mk_quad(0, 0, 21, 0, 21, 5, 0, 5, 1, 0, 0);
		cases.push_back('{q, 1, mk_span(0, 0, 0, 0, q)});
		// plate column at the plate size
		q = mk_quad(1, 1, 1, 1, 1, 1, 1, 1, 2, 480, 0);
		cases.push_back('{q, 1, mk_span(0, 0, 0, 0, q)});
		// plate row far off the plate
		q = mk_quad(1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 2047);
		cases.push_back('{q, 1, mk_span(0, 0, 0, 0, q)});
		// most negative point: row above the lens
		q = mk_quad(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, 15, 0, 0);
		cases.push_back('{q, 1, mk_span(0, 0, 0, 0, q)});
		// most positive point: row below the lens
		q = mk_quad(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 5, 7, 9);
		cases.push_back('{q, 1, mk_span(0, 0, 0, 0, q)});
		// horizontal line clipped at the right edge
		q = mk_quad(630, 10, 645, 10, 645, 10, 630, 10, 4, 3, 3);
		cases.push_back('{q, 1, mk_span(10, 630, 639, 1, q)});
		// horizontal line clipped at the left edge
		q = mk_quad(-5, 0, 3, 0, 3, 0, -5, 0, 6, 10, 11);
		cases.push_back('{q, 1, mk_span(0, 0, 3, 1, q)});
		// last plate pixel, last lens row
		q = mk_quad(0, 479, 0, 479, 0, 479, 0, 479, 15, 479, 479);
		cases.push_back('{q, 1, mk_span(479, 0, 0, 1, q)});
		// vertical line one taller than the limit
		q = mk_quad(3, 0, 3, 0, 3, 21, 3, 21, 8, 0, 0);
		cases.push_back('{q, 1, mk_span(0, 0, 0, 0, q)});
		// sign bits on the corners, huge box
		q = mk_quad(-2048, 5, 2047, 5, 2047, 6, -2048, 6, 9, 100, 200);
		cases.push_back('{q, 1, mk_span(0, 0, 0, 0, q)});
		// predicted shapes: vertical line, square, diamond, skew, full box,
		// bowtie, and one crossing the bottom and right edges of the lens
		cases.push_back('{mk_quad(4, 2, 4, 2, 4, 6, 4, 6, 1, 1, 1), 0, none});
		cases.push_back('{mk_quad(10, 10, 20, 10, 20, 20, 10, 20, 2, 2, 2), 0, none});
		cases.push_back('{mk_quad(10, 0, 15, 5, 10, 10, 5, 5, 3, 3, 3), 0, none});
		cases.push_back('{mk_quad(-7, -3, 5, -1, 9, 8, -9, 6, 4, 4, 4), 0, none});
		cases.push_back('{mk_quad(100, 100, 120, 100, 120, 120, 100, 120, 5, 5, 5), 0, none});
		cases.push_back('{mk_quad(0, 0, 10, 10, 10, 0, 0, 10, 6, 6, 6), 0, none});
		cases.push_back('{mk_quad(630, 470, 649, 475, 640, 489, 625, 480, 7, 8, 9), 0, none});
		foreach (cases[i])
			send_quad(cases[i].q, cases[i].typed, cases[i].e);
		drain();

		// random phases, each under its own settings, extremes included;
		// a write to the unused index must leave everything alone
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_reg(RI_UNUSED, 7);
				1: set_lens(1, 1, 1);
				2: set_lens(2048, 2048, 2048);
				3: set_lens(30, 25, 12);
				4: set_lens(0, 0, 0);
				5: set_lens(4095, 4095, 4095);
				6: set_lens(64, 2048, 40);
				default: set_lens(640, 480, 480);
			endcase
			for (int k = 0; k < RANDOM_QUADS / 8; k++) begin
				// stretches with no idling on either side
				if ($urandom_range(0, 15) == 0)
					burst_mode = !burst_mode;
				send_quad(rand_quad(), 0, none);
			end
			burst_mode = 0;
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && span_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
